// ----- sv/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg: shared constants for the sorted priority queue
// Default queue depth, entry field widths and response status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

   // default number of queue slots
   localparam int DEPTH_DEFAULT = 16;

   // entry field widths
   localparam int PRI_W  = 8;
   localparam int DATA_W = 32;
   localparam int KEY_W  = PRI_W + DATA_W;

   // response field widths
   localparam int STAT_W = 2;
   localparam int OCC_W  = 5;

   // command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // response status codes
   typedef enum logic [STAT_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

endpackage

// ----- sv/spq_ram.sv -----
// ----------------------------------------------------------------------------
// spq_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module spq_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- sv/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue: priority queue kept as a sorted array
// Holds up to DEPTH entries (8-bit priority, 32-bit signed data) in a RAM,
// sorted ascending by (priority, data) from a circular head pointer. A remove
// returns the head entry and advances the head. An insert walks from the rear
// toward the head with one 40-bit comparator and the single RAM read and write
// port, moving each larger entry back one slot per cycle. An insert into an
// empty queue writes the new entry straight to the head slot; any other insert
// reads the rear entry, then compares and shifts until the new entry finds its
// place. An insert into a full queue or a remove from an empty one answers
// with a status and leaves the store alone. The block takes no new beat while
// an item is in work, but it takes the next beat while a finished response
// still waits in the output register.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [spq_pkg::PRI_W-1:0]       req_entry_priority,
   input  logic signed [spq_pkg::DATA_W-1:0] req_entry_data,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [spq_pkg::STAT_W-1:0]      rsp_status,
   output logic [spq_pkg::PRI_W-1:0]       rsp_removed_priority,
   output logic signed [spq_pkg::DATA_W-1:0] rsp_removed_data,
   output logic [spq_pkg::OCC_W-1:0]       rsp_occupancy
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW:0]   DEPTH_SUM = (IW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_REM_RD,
      ST_REM_TAKE,
      ST_REPLY
   } state_type;

   state_type                      state_ff, state_in;
   logic [IW-1:0]                  head_ff, head_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [IW-1:0]                  idx_ff, idx_in;
   logic                           cmd_ff, cmd_in;
   logic [spq_pkg::KEY_W-1:0]      entry_ff, entry_in;
   spq_pkg::status_type            stat_ff, stat_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [spq_pkg::STAT_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [spq_pkg::PRI_W-1:0]      rsp_pri_ff, rsp_pri_in;
   logic [spq_pkg::DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [CW-1:0]                  rsp_count_ff, rsp_count_in;

   logic                           ram_we;
   logic [IW-1:0]                  ram_waddr;
   logic [spq_pkg::KEY_W-1:0]      ram_wdata;
   logic [IW-1:0]                  ram_raddr;
   logic [spq_pkg::KEY_W-1:0]      ram_rdata;

   logic                           req_accept;
   logic                           out_free;
   logic                           new_less;
   logic [IW-1:0]                  idx_prev;
   logic [CW+spq_pkg::OCC_W-1:0]   occ_wide;

   // physical slot of a position counted from the head
   function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                              input logic [IW-1:0] off);
      logic [IW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DEPTH_SUM) begin
         sum = sum - DEPTH_SUM;
      end
      return sum[IW-1:0];
   endfunction

   // compare key: priority on top, data with its sign bit flipped below
   function automatic logic [spq_pkg::KEY_W-1:0] key_of(
         input logic [spq_pkg::KEY_W-1:0] entry);
      return entry ^ {{spq_pkg::PRI_W{1'b0}}, 1'b1, {(spq_pkg::DATA_W-1){1'b0}}};
   endfunction

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign new_less   = key_of(entry_ff) < key_of(ram_rdata);
   assign idx_prev   = (idx_ff == '0) ? '0 : idx_ff - IW'(1);

   // RAM read address follows the state
   always_comb begin
      unique case (state_ff)
         ST_INS_RD:  ram_raddr = slot_of(head_ff, idx_ff);
         ST_INS_CMP: ram_raddr = slot_of(head_ff, idx_prev);
         default:    ram_raddr = head_ff;
      endcase
   end

   // RAM write: move a larger entry back, or drop the new entry in place
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = slot_of(head_ff, idx_ff);
      ram_wdata = entry_ff;
      unique case (state_ff)
         ST_INS_CMP: begin
            ram_we    = 1'b1;
            ram_waddr = slot_of(head_ff, idx_ff + IW'(1));
            ram_wdata = new_less ? ram_rdata : entry_ff;
         end
         ST_INS_PUT: begin
            ram_we = 1'b1;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   spq_ram #(
      .WIDTH (spq_pkg::KEY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // sequencer next state and response register
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cmd_in        = cmd_ff;
      entry_in      = entry_ff;
      stat_in       = stat_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_pri_in    = rsp_pri_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in   = req_command;
               entry_in = {req_entry_priority, req_entry_data};
               stat_in  = spq_pkg::STAT_DONE;
               idx_in   = '0;
               if (req_command == spq_pkg::CMD_INSERT) begin
                  if (count_ff == DEPTH_CNT) begin
                     stat_in  = spq_pkg::STAT_FULL;
                     state_in = ST_REPLY;
                  end else if (count_ff == '0) begin
                     state_in = ST_INS_PUT;
                  end else begin
                     idx_in   = IW'(count_ff - CW'(1));
                     state_in = ST_INS_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     stat_in  = spq_pkg::STAT_EMPTY;
                     state_in = ST_REPLY;
                  end else begin
                     state_in = ST_REM_RD;
                  end
               end
            end
         end
         ST_INS_RD: begin
            state_in = ST_INS_CMP;
         end
         ST_INS_CMP: begin
            // shift while the new entry sorts ahead; stop at the first not larger
            if (!new_less) begin
               state_in = ST_REPLY;
            end else if (idx_ff == '0) begin
               state_in = ST_INS_PUT;
            end else begin
               idx_in = idx_prev;
            end
         end
         ST_INS_PUT: begin
            state_in = ST_REPLY;
         end
         ST_REM_RD: begin
            state_in = ST_REM_TAKE;
         end
         ST_REM_TAKE: begin
            // hand out the head entry and advance the head
            if (out_free) begin
               head_in       = slot_of(head_ff, IW'(1));
               count_in      = count_ff - CW'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = spq_pkg::STAT_DONE;
               rsp_pri_in    = ram_rdata[spq_pkg::KEY_W-1:spq_pkg::DATA_W];
               rsp_data_in   = ram_rdata[spq_pkg::DATA_W-1:0];
               rsp_count_in  = count_ff - CW'(1);
               state_in      = ST_IDLE;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               if (stat_ff == spq_pkg::STAT_DONE) begin
                  count_in = count_ff + CW'(1);
               end
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_pri_in    = '0;
               rsp_data_in   = '0;
               rsp_count_in  = (stat_ff == spq_pkg::STAT_DONE) ? count_ff + CW'(1)
                                                              : count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      cmd_ff        <= cmd_in;
      entry_ff      <= entry_in;
      stat_ff       <= stat_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pri_ff    <= rsp_pri_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // occupancy field carries the low bits of the count
   assign occ_wide = {{spq_pkg::OCC_W{1'b0}}, rsp_count_ff};

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_removed_priority = rsp_pri_ff;
   assign rsp_removed_data     = rsp_data_ff;
   assign rsp_occupancy        = occ_wide[spq_pkg::OCC_W-1:0];

`ifndef ASSERT_OFF
   // the count never runs past the number of slots
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue count exceeds depth");

   // only the insert walk writes the store
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_INS_CMP || state_ff == ST_INS_PUT))
      else $error("store written outside an insert");

   // the head moves only when a remove hands out its entry
   a_head_move: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_REM_TAKE || !out_free) |=> $stable(head_ff))
      else $error("head moved without a remove");

   // an insert walk only starts on a queue with room
   a_ins_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_RD) |-> (count_ff != DEPTH_CNT && count_ff != '0 &&
                                   cmd_ff == spq_pkg::CMD_INSERT))
      else $error("insert walk on full or empty queue");
`endif

endmodule
